/* rtl/irqc_pkg.sv */
`timescale 1ns / 1ps

package irqc_pkg;

  localparam int unsigned NumSourcesDefault = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [5:0] OFS_STATUS   = 6'h00;
  localparam logic [5:0] OFS_RAW      = 6'h04;
  localparam logic [5:0] OFS_EN_SET   = 6'h08;
  localparam logic [5:0] OFS_EN_CLR   = 6'h0c;
  localparam logic [5:0] OFS_SOFT_SET = 6'h10;
  localparam logic [5:0] OFS_SOFT_CLR = 6'h14;
  localparam logic [5:0] OFS_PASS_SET = 6'h20;
  localparam logic [5:0] OFS_PASS_CLR = 6'h24;

  localparam logic [CfgIdxW-1:0] CFG_SRC_MASK    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_NUMBER = 1'd1;

  localparam logic [DataW-1:0] NONE_ACTIVE = '1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [5:0]       offset;
    logic [DataW-1:0] write_data;
    logic [DataW-1:0] source_lines;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_out;
    logic [IdxW-1:0]  lowest_source;
    logic [DataW-1:0] host_number;
    logic [DataW-1:0] pass_enable;
  } out_word_t;

endpackage

/* rtl/irq_enable_status_controller_unit.sv */
`timescale 1ns / 1ps

// Path: each word passes the input register, then the result register.
// Throughput: one word per cycle; the input stalls only while the input register holds
// a word and the finished result in the result register is stalled.
// Reset: enable, soft-pending and pass-through bits clear, source mask all ones,
// base_number zero, both pipeline stages empty.
module irq_enable_status_controller_unit #(
  parameter int unsigned NUM_SOURCES = irqc_pkg::NumSourcesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  irqc_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output irqc_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  logic [irqc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [irqc_pkg::DataW-1:0]    cfg_data_i
);
  import irqc_pkg::*;

  localparam int unsigned N = NUM_SOURCES;

  logic             s1_valid_q;
  in_word_t         s1_q;
  logic             out_valid_q;
  out_word_t        out_q, out_d;
  logic             out_ready;
  logic             advance;

  logic [DataW-1:0] src_mask_q;
  logic [DataW-1:0] base_q;
  logic [N-1:0]     en_q, en_d;
  logic [N-1:0]     soft_q, soft_d;
  logic [N-1:0]     pass_q, pass_d;

  logic [N-1:0]     wd, lines, raw, status;
  logic [IdxW-1:0]  low;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_ready;
  assign in_stall_o  = s1_valid_q && !out_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_word_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_mask_q <= '1;
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SRC_MASK:    src_mask_q <= cfg_data_i;
        CFG_BASE_NUMBER: base_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state update and result forming; writes land before status is formed
  always_comb begin
    wd     = s1_q.write_data[N-1:0];
    lines  = s1_q.source_lines[N-1:0];
    en_d   = en_q;
    soft_d = soft_q;
    pass_d = pass_q;
    if (s1_q.opcode == OP_WRITE) begin
      case (s1_q.offset)
        OFS_EN_SET:   en_d   = en_q | wd;
        OFS_EN_CLR:   en_d   = en_q & ~wd;
        OFS_SOFT_SET: soft_d = soft_q | wd;
        OFS_SOFT_CLR: soft_d = soft_q & ~wd;
        OFS_PASS_SET: pass_d = pass_q | wd;
        OFS_PASS_CLR: pass_d = pass_q & ~wd;
        default: ;
      endcase
    end

    raw    = lines | soft_d;
    status = raw & en_d & src_mask_q[N-1:0];

    // lowest set bit wins: scan from the top down
    low = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (status[i]) begin
        low = IdxW'(i);
      end
    end

    out_d.read_data = '0;
    if (s1_q.opcode == OP_READ) begin
      case (s1_q.offset)
        OFS_STATUS:   out_d.read_data = DataW'(status);
        OFS_RAW:      out_d.read_data = DataW'(raw);
        OFS_EN_SET:   out_d.read_data = DataW'(en_d);
        OFS_SOFT_SET: out_d.read_data = DataW'(soft_d);
        OFS_PASS_SET: out_d.read_data = DataW'(pass_d);
        default:      out_d.read_data = '0;
      endcase
    end
    out_d.irq_out       = |status;
    out_d.lowest_source = low;
    out_d.host_number   = (|status) ? (base_q + DataW'(low)) : NONE_ACTIVE;
    out_d.pass_enable   = DataW'(pass_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      soft_q <= '0;
      pass_q <= '0;
    end else if (advance) begin
      en_q   <= en_d;
      soft_q <= soft_d;
      pass_q <= pass_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  a_none_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.irq_out |-> out_q.lowest_source == '0 &&
                                      out_q.host_number == NONE_ACTIVE)
    else $error("idle result carries a source");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipe");

  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("word lost between stages");

  a_pass_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.pass_enable & ~DataW'(pass_q)) == '0 ||
                    $past(advance))
    else $error("pass-through bits outside stored set");

endmodule
